// ===== src/lkvc_pkg.sv =====
// Package for the LRU key/value cache: status codes, mode codes, sequencer states and the
// layout of one stored entry. No dependencies.

package lkvc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int STAMP_W = 32;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_UPDATE  = 3'd1;
    localparam logic [2:0] ST_REPLACE = 3'd2;
    localparam logic [2:0] ST_HIT     = 3'd3;
    localparam logic [2:0] ST_MISS    = 3'd4;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

// ===== src/lkvc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg and lkvc_ram.

// A command is taken at a rising edge with start high and busy low; busy then
// stays high through the scan, drain and write states, and the next command
// can be taken at the end of the first cycle with busy low. The scan sets the
// pace: key, value and stamp of every entry sit in one RAM whose single read
// port visits one entry per cycle, followed by a drain state for the last
// read, a write state that writes the chosen entry back and an idle state in
// which the next command is taken. The result appears on the o_ ports with
// o_strobe high for exactly one cycle, the first cycle with busy low; the
// receiver cannot stall it, so capture it then. A new command may be started
// in that same cycle. Capacity is written through the cfg channel (always
// ready); the user must write it only while the block is idle, which the block
// itself does not enforce. 0 acts as 1 and values above ENTRIES act as
// ENTRIES. Valid bits are flip-flops cleared by reset, so no clearing pass is
// needed.

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    // result channel
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [31:0] o_read_value,
    output logic [3:0]  o_slot,
    output logic [31:0] o_evicted_key,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [8:0]    ENTRIES_9 = 9'(ENTRIES);
    localparam logic [31:0]   STAMP_MAX = 32'hFFFF_FFFF;

    // control state
    lkvc_pkg::t_state r_state, n_state;
    logic [ENTRIES-1:0] r_valid;
    logic [4:0]         r_capacity;
    logic [31:0]        r_use;
    logic [IW-1:0]      r_addr;
    logic               r_chk;
    logic [IW-1:0]      r_chk_idx;
    logic               r_strobe;

    // captured command
    logic        r_mode;
    logic [31:0] r_key;
    logic [31:0] r_val;

    // scan trackers
    logic          r_hit_f;
    logic [IW-1:0] r_hit_idx;
    logic [31:0]   r_hit_val;
    logic          r_vic_f;
    logic [IW-1:0] r_vic_idx;
    logic [31:0]   r_vic_stamp;
    logic [31:0]   r_vic_key;
    logic          r_free_f;
    logic [IW-1:0] r_free_idx;
    logic [CW-1:0] r_count;

    // result registers
    logic [2:0]    r_status;
    logic [31:0]   r_rdata;
    logic [IW-1:0] r_slot;
    logic [31:0]   r_evict;

    // RAM interface
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    lkvc_pkg::t_entry ram_wdata;
    logic             ram_re;
    lkvc_pkg::t_entry ram_rdata;

    // write-phase decision
    logic          accept;
    logic [8:0]    cap_eff;
    logic [31:0]   stamp_next;
    logic          set_valid;
    logic          bump_use;
    logic [2:0]    n_status;
    logic [31:0]   n_rdata;
    logic [IW-1:0] n_slot;
    logic [31:0]   n_evict;
    logic [IW+3:0] slot_wide;

    assign accept      = start && !busy;
    assign busy        = (r_state != lkvc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign stamp_next  = (r_use == STAMP_MAX) ? r_use : r_use + 32'd1;

    lkvc_ram #(
        .WIDTH ($bits(lkvc_pkg::t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Clamp capacity to 1..ENTRIES.
    always_comb begin
        cap_eff = {4'b0, r_capacity};
        if (cap_eff == 9'd0) begin
            cap_eff = 9'd1;
        end else if (cap_eff > ENTRIES_9) begin
            cap_eff = ENTRIES_9;
        end
    end

    // Sequencer: scan every entry, drain the last read, then write back.
    always_comb begin
        n_state = r_state;
        ram_re  = 1'b0;
        unique case (r_state)
            lkvc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = lkvc_pkg::S_SCAN;
                end
            end
            lkvc_pkg::S_SCAN: begin
                ram_re = 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_state = lkvc_pkg::S_DRAIN;
                end
            end
            lkvc_pkg::S_DRAIN: begin
                n_state = lkvc_pkg::S_WRITE;
            end
            lkvc_pkg::S_WRITE: begin
                n_state = lkvc_pkg::S_IDLE;
            end
            default: begin
                n_state = lkvc_pkg::S_IDLE;
            end
        endcase
    end

    // Decide the write-back and the result from the finished scan.
    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = r_hit_idx;
        ram_wdata.key   = r_key;
        ram_wdata.value = r_val;
        ram_wdata.stamp = stamp_next;
        set_valid       = 1'b0;
        bump_use        = 1'b1;
        n_status        = lkvc_pkg::ST_MISS;
        n_rdata         = 32'd0;
        n_slot          = '0;
        n_evict         = 32'd0;
        priority if (r_mode == lkvc_pkg::MODE_READ) begin
            if (r_hit_f) begin
                // Restamp a hit, keep its value.
                ram_we          = 1'b1;
                ram_wdata.value = r_hit_val;
                n_status        = lkvc_pkg::ST_HIT;
                n_rdata         = r_hit_val;
                n_slot          = r_hit_idx;
            end else begin
                bump_use = 1'b0;
            end
        end else if (r_hit_f) begin
            ram_we   = 1'b1;
            n_status = lkvc_pkg::ST_UPDATE;
            n_slot   = r_hit_idx;
        end else if ((9'(r_count) < cap_eff) && r_free_f) begin
            // Fill the lowest free entry; the first fill of an empty cache
            // takes the counter as it stands.
            ram_we    = 1'b1;
            ram_waddr = r_free_idx;
            set_valid = 1'b1;
            n_status  = lkvc_pkg::ST_NEW;
            n_slot    = r_free_idx;
            if (r_count == '0) begin
                ram_wdata.stamp = r_use;
                bump_use        = 1'b0;
            end
        end else begin
            // Replace the oldest valid entry, key included.
            ram_we    = 1'b1;
            ram_waddr = r_vic_idx;
            n_status  = lkvc_pkg::ST_REPLACE;
            n_slot    = r_vic_idx;
            n_evict   = r_vic_key;
        end
        if (r_state != lkvc_pkg::S_WRITE) begin
            ram_we    = 1'b0;
            set_valid = 1'b0;
            bump_use  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lkvc_pkg::S_IDLE;
            r_valid    <= '0;
            r_capacity <= 5'd16;
            r_use      <= 32'd0;
            r_addr     <= '0;
            r_chk      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chk    <= ram_re;
            r_strobe <= (r_state == lkvc_pkg::S_WRITE);
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (accept) begin
                r_addr <= '0;
            end else if (ram_re && (r_addr != LAST_IDX)) begin
                r_addr <= r_addr + IW'(1);
            end
            if (set_valid) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (bump_use) begin
                r_use <= stamp_next;
            end
        end
    end

    // Capture the command, clear trackers on accept, fold in each read beat.
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_addr;
        if (accept) begin
            r_mode   <= i_mode;
            r_key    <= i_key;
            r_val    <= i_value;
            r_hit_f  <= 1'b0;
            r_vic_f  <= 1'b0;
            r_free_f <= 1'b0;
            r_count  <= '0;
        end else if (r_chk) begin
            if (r_valid[r_chk_idx]) begin
                r_count <= r_count + CW'(1);
                if (!r_hit_f && (ram_rdata.key == r_key)) begin
                    r_hit_f   <= 1'b1;
                    r_hit_idx <= r_chk_idx;
                    r_hit_val <= ram_rdata.value;
                end
                // Strict less-than keeps the lowest index among equal stamps.
                if (!r_vic_f || (ram_rdata.stamp < r_vic_stamp)) begin
                    r_vic_f     <= 1'b1;
                    r_vic_idx   <= r_chk_idx;
                    r_vic_stamp <= ram_rdata.stamp;
                    r_vic_key   <= ram_rdata.key;
                end
            end else if (!r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
        end
        if (r_state == lkvc_pkg::S_WRITE) begin
            r_status <= n_status;
            r_rdata  <= n_rdata;
            r_slot   <= n_slot;
            r_evict  <= n_evict;
        end
    end

    assign slot_wide     = {4'b0, r_slot};
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_read_value  = r_rdata;
    assign o_slot        = slot_wide[3:0];
    assign o_evicted_key = r_evict;

endmodule
